@@ rtl/core/tcyk_pkg.sv @@
// tcyk_pkg: shared widths, constants, register indexes, sequencer states and the
// cordic arctangent table for the tilt compass yaw filter
// no dependencies
package tcyk_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_LIMIT   = 24;
  localparam int NSTEPS = (CORDIC_STEPS > STEP_LIMIT) ? STEP_LIMIT :
                          ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
  localparam int STEP_W = $clog2(STEP_LIMIT + 1);

  // serial multiplier
  localparam int MA_W = 34;
  localparam int MB_W = 33;
  localparam int MP_W = MA_W + MB_W;
  localparam int MN_W = 6;

  // serial divider
  localparam int DQ_W = 33;
  localparam int DR_W = 34;
  localparam int NUM_W = 65;

  // cordic
  localparam int CX_W = 56;
  localparam int CZ_W = 34;
  localparam int TRIG_W = 18;

  localparam logic [31:0] DEFAULT_Q  = 32'd7;
  localparam logic [31:0] DEFAULT_R  = 32'd3277;
  localparam logic [DR_W-1:0] PRED_DIV  = 34'd1406250;
  localparam logic [NUM_W-1:0] PRED_HALF = 65'd703125;
  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 56'sd652032874;
  localparam logic signed [CZ_W-1:0] ANG90  = 34'sd1073741824;
  localparam logic signed [CZ_W-1:0] ANG180 = 34'sd2147483648;
  localparam logic signed [CZ_W-1:0] HEAD_ROUND = 34'sd32768;

  typedef enum logic [2:0] {
    REG_PROCESS_NOISE,
    REG_MEASURE_NOISE,
    REG_GYRO_BIAS,
    REG_MAG_OFS_X,
    REG_MAG_OFS_Y,
    REG_MAG_OFS_Z,
    REG_MAG_SCALE_Y_REL,
    REG_MAG_SCALE_Z_REL
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PRED_MUL,
    S_PRED_DIV,
    S_MY_MUL,
    S_MZ_MUL,
    S_SIN_ROLL,
    S_SIN_PITCH,
    S_SRSP_MUL,
    S_SRCP_MUL,
    S_XH_MUL1,
    S_XH_MUL2,
    S_YH_MUL1,
    S_YH_MUL2,
    S_YH_MUL3,
    S_HEADING,
    S_CORR_MUL,
    S_CORR_DIV,
    S_COV_MUL,
    S_COV_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic vector;
  } cordic_ctl_t;

  function automatic logic signed [CZ_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic signed [CZ_W-1:0] v;
    case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/tcyk_if.sv @@
// tcyk_in_if, tcyk_out_if: valid/ready channels for samples and results
// no dependencies
interface tcyk_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] gyro_rate;
  logic        [15:0] time_step;
  logic signed [15:0] mag_raw_x;
  logic signed [15:0] mag_raw_y;
  logic signed [15:0] mag_raw_z;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;

  modport source (output valid, gyro_rate, time_step, mag_raw_x, mag_raw_y, mag_raw_z,
                  roll_angle, pitch_angle, input ready);
  modport sink (input valid, gyro_rate, time_step, mag_raw_x, mag_raw_y, mag_raw_z,
                roll_angle, pitch_angle, output ready);
endinterface

interface tcyk_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;
  logic               compass_used;
  logic        [31:0] covariance;

  modport source (output valid, yaw_angle, compass_used, covariance, input ready);
  modport sink (input valid, yaw_angle, compass_used, covariance, output ready);
endinterface

@@ rtl/core/tilt_compass_yaw_kalman_core.sv @@
// tilt_compass_yaw_kalman_core: yaw kalman filter with tilt-compensated compass,
// sequencer over a serial multiplier, a serial divider and a shared cordic
// depends on tcyk_pkg, tcyk_if, tcyk_mul, tcyk_div, tcyk_cordic
//
//   channel  dir  handshake       payload
//   in_ch    in   valid/ready     gyro_rate time_step mag_raw_x/y/z roll_angle pitch_angle
//   out_ch   out  valid/ready     yaw_angle compass_used covariance
//   cfg      in   cfg_write       cfg_index cfg_data
//
// one request at a time, handled by the serial multiplier (one multiplier bit per
// cycle, twelve products), the divider (one quotient bit per cycle, three quotients)
// and three cordic runs of CORDIC_STEPS steps; with no compass vector only three
// products and one quotient; with a zero horizontal vector the heading run is skipped
// a new request is taken once the result sits in the output register
// rst is synchronous: yaw 0, covariance 1.0, registers to defaults
module tilt_compass_yaw_kalman_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  tcyk_in_if.sink     in_ch,
  tcyk_out_if.source  out_ch
);
  import tcyk_pkg::*;

  state_t state, state_next;

  // configuration
  logic [31:0]        process_noise;
  logic [31:0]        measure_noise;
  logic signed [23:0] gyro_bias;
  logic signed [15:0] mag_ofs_x;
  logic signed [15:0] mag_ofs_y;
  logic signed [15:0] mag_ofs_z;
  logic [15:0]        mag_scale_y_rel;
  logic [15:0]        mag_scale_z_rel;

  // filter state
  logic signed [15:0] yaw;
  logic [31:0]        cov;

  // working registers
  logic signed [24:0]       rate;
  logic [15:0]              dt;
  logic signed [16:0]       dmx;
  logic signed [16:0]       dmy;
  logic signed [16:0]       dmz;
  logic signed [15:0]       roll;
  logic signed [15:0]       pitch;
  logic [31:0]              p;
  logic [31:0]              r_eff;
  logic [32:0]              den_r;
  logic [NUM_W-1:0]         num;
  logic                     pneg;
  logic signed [15:0]       pred;
  logic signed [32:0]       my;
  logic signed [32:0]       mz;
  logic signed [TRIG_W-1:0] sr, cr, sp, cp, srsp, srcp;
  logic signed [CX_W-1:0]   xh;
  logic signed [CX_W-1:0]   yh;
  logic                     trig_neg;
  logic                     dneg;
  logic [16:0]              dmag;
  logic                     used;
  logic                     issued;

  logic                     out_valid;
  logic signed [15:0]       out_yaw;
  logic                     out_used;
  logic [31:0]              out_cov;

  // unit ports
  logic                   mul_start, mul_done;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic [MN_W-1:0]        mn;
  logic signed [MP_W-1:0] prod;
  logic                   div_start, div_done;
  logic [DR_W-1:0]        drem;
  logic [DQ_W-1:0]        dlow;
  logic [DR_W-1:0]        dden;
  logic [MN_W-1:0]        dn;
  logic [DQ_W-1:0]        quo;
  cordic_ctl_t            cor_ctl;
  logic                   cor_done;
  logic signed [CX_W-1:0] cx0, cy0, cx, cy;
  logic signed [CZ_W-1:0] cz0, cz;

  logic                   go;
  logic                   in_take;
  logic                   out_load;
  logic                   xy_zero;
  logic                   mag_zero;
  logic signed [15:0]     sel_ang;
  logic signed [CZ_W-1:0] zang;
  logic                   ang_hi, ang_lo;
  logic [32:0]            p_sum;
  logic signed [MP_W-1:0] prod_abs;
  logic signed [TRIG_W-1:0] ys, xs;
  logic signed [CZ_W-1:0] head_sum;
  logic signed [15:0]     head;
  logic signed [15:0]     dval;
  logic [15:0]            dabs;
  logic signed [15:0]     pinc;
  logic signed [15:0]     cinc;

  tcyk_mul u_mul (
    .clk, .rst, .start(mul_start), .a(ma), .b(mb), .n(mn), .done(mul_done), .prod
  );

  tcyk_div u_div (
    .clk, .rst, .start(div_start), .rem0(drem), .low(dlow), .den(dden), .n(dn),
    .done(div_done), .quo
  );

  tcyk_cordic u_cordic (
    .clk, .rst, .ctl(cor_ctl), .x0(cx0), .y0(cy0), .z0(cz0), .done(cor_done),
    .x(cx), .y(cy), .z(cz)
  );

  assign in_ch.ready      = (state == S_IDLE);
  assign in_take          = in_ch.valid && in_ch.ready;
  assign out_load         = (state == S_DONE) && (!out_valid || out_ch.ready);
  assign out_ch.valid     = out_valid;
  assign out_ch.yaw_angle = out_yaw;
  assign out_ch.compass_used = out_used;
  assign out_ch.covariance   = out_cov;

  assign go       = !issued;
  assign xy_zero  = (xh == '0) && (yh == '0);
  assign mag_zero = (dmx == '0) && (my == '0) && (prod[32:0] == '0);

  assign sel_ang = (state == S_SIN_ROLL) ? roll : pitch;
  assign zang    = {{2{sel_ang[15]}}, sel_ang, 16'h0000};
  assign ang_hi  = zang > ANG90;
  assign ang_lo  = zang < -ANG90;

  assign p_sum    = {1'b0, cov} + {1'b0, (process_noise != '0) ? process_noise : DEFAULT_Q};
  assign prod_abs = prod[MP_W-1] ? -prod : prod;
  assign ys       = cy[32:15];
  assign xs       = cx[32:15];
  assign head_sum = cz + HEAD_ROUND;
  assign head     = xy_zero ? 16'sd0 : head_sum[31:16];
  assign dval     = head - pred;
  assign dabs     = dval[15] ? 16'(-dval) : dval;
  assign pinc     = pneg ? -quo[15:0] : quo[15:0];
  assign cinc     = dneg ? -quo[15:0] : quo[15:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise   <= DEFAULT_Q;
      measure_noise   <= DEFAULT_R;
      gyro_bias       <= '0;
      mag_ofs_x       <= '0;
      mag_ofs_y       <= '0;
      mag_ofs_z       <= '0;
      mag_scale_y_rel <= 16'd16384;
      mag_scale_z_rel <= 16'd16384;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_PROCESS_NOISE:   process_noise   <= cfg_data;
        REG_MEASURE_NOISE:   measure_noise   <= cfg_data;
        REG_GYRO_BIAS:       gyro_bias       <= cfg_data[23:0];
        REG_MAG_OFS_X:       mag_ofs_x       <= cfg_data[15:0];
        REG_MAG_OFS_Y:       mag_ofs_y       <= cfg_data[15:0];
        REG_MAG_OFS_Z:       mag_ofs_z       <= cfg_data[15:0];
        REG_MAG_SCALE_Y_REL: mag_scale_y_rel <= cfg_data[15:0];
        REG_MAG_SCALE_Z_REL: mag_scale_z_rel <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_take) state_next = S_PRED_MUL;
      S_PRED_MUL:  if (mul_done) state_next = S_PRED_DIV;
      S_PRED_DIV:  if (div_done) state_next = S_MY_MUL;
      S_MY_MUL:    if (mul_done) state_next = S_MZ_MUL;
      S_MZ_MUL:    if (mul_done) state_next = mag_zero ? S_DONE : S_SIN_ROLL;
      S_SIN_ROLL:  if (cor_done) state_next = S_SIN_PITCH;
      S_SIN_PITCH: if (cor_done) state_next = S_SRSP_MUL;
      S_SRSP_MUL:  if (mul_done) state_next = S_SRCP_MUL;
      S_SRCP_MUL:  if (mul_done) state_next = S_XH_MUL1;
      S_XH_MUL1:   if (mul_done) state_next = S_XH_MUL2;
      S_XH_MUL2:   if (mul_done) state_next = S_YH_MUL1;
      S_YH_MUL1:   if (mul_done) state_next = S_YH_MUL2;
      S_YH_MUL2:   if (mul_done) state_next = S_YH_MUL3;
      S_YH_MUL3:   if (mul_done) state_next = S_HEADING;
      S_HEADING:   if (xy_zero || cor_done) state_next = S_CORR_MUL;
      S_CORR_MUL:  if (mul_done) state_next = S_CORR_DIV;
      S_CORR_DIV:  if (div_done) state_next = S_COV_MUL;
      S_COV_MUL:   if (mul_done) state_next = S_COV_DIV;
      S_COV_DIV:   if (div_done) state_next = S_DONE;
      S_DONE:      if (out_load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // unit requests and operand selection
  always_comb begin
    mul_start      = 1'b0;
    ma             = '0;
    mb             = '0;
    mn             = '0;
    div_start      = 1'b0;
    drem           = '0;
    dlow           = '0;
    dden           = '0;
    dn             = '0;
    cor_ctl.start  = 1'b0;
    cor_ctl.vector = 1'b0;
    cx0            = CORDIC_GAIN;
    cy0            = '0;
    cz0            = ang_hi ? zang - ANG180 : (ang_lo ? zang + ANG180 : zang);
    case (state)
      S_PRED_MUL: begin
        mul_start = go;
        ma = MA_W'(rate);
        mb = MB_W'(dt);
        mn = MN_W'(17);
      end
      S_PRED_DIV: begin
        div_start = go;
        drem = DR_W'(num >> 21);
        dlow = {num[20:0], 12'h000};
        dden = PRED_DIV;
        dn   = MN_W'(21);
      end
      S_MY_MUL: begin
        mul_start = go;
        ma = MA_W'(dmy);
        mb = MB_W'(mag_scale_y_rel);
        mn = MN_W'(17);
      end
      S_MZ_MUL: begin
        mul_start = go;
        ma = MA_W'(dmz);
        mb = MB_W'(mag_scale_z_rel);
        mn = MN_W'(17);
      end
      S_SIN_ROLL, S_SIN_PITCH: begin
        cor_ctl.start = go;
      end
      S_SRSP_MUL: begin
        mul_start = go;
        ma = MA_W'(sr);
        mb = MB_W'(sp);
        mn = MN_W'(TRIG_W);
      end
      S_SRCP_MUL: begin
        mul_start = go;
        ma = MA_W'(sr);
        mb = MB_W'(cp);
        mn = MN_W'(TRIG_W);
      end
      S_XH_MUL1: begin
        mul_start = go;
        ma = MA_W'($signed({dmx, 14'h0000}));
        mb = MB_W'(cp);
        mn = MN_W'(TRIG_W);
      end
      S_XH_MUL2: begin
        mul_start = go;
        ma = MA_W'(mz);
        mb = MB_W'(sp);
        mn = MN_W'(TRIG_W);
      end
      S_YH_MUL1: begin
        mul_start = go;
        ma = MA_W'($signed({dmx, 14'h0000}));
        mb = MB_W'(srsp);
        mn = MN_W'(TRIG_W);
      end
      S_YH_MUL2: begin
        mul_start = go;
        ma = MA_W'(my);
        mb = MB_W'(cr);
        mn = MN_W'(TRIG_W);
      end
      S_YH_MUL3: begin
        mul_start = go;
        ma = MA_W'(mz);
        mb = MB_W'(srcp);
        mn = MN_W'(TRIG_W);
      end
      S_HEADING: begin
        cor_ctl.start  = go && !xy_zero;
        cor_ctl.vector = 1'b1;
        cx0 = xh[CX_W-1] ? -xh : xh;
        cy0 = xh[CX_W-1] ? yh : -yh;
        cz0 = xh[CX_W-1] ? ANG180 : '0;
      end
      S_CORR_MUL: begin
        mul_start = go;
        ma = MA_W'(p);
        mb = MB_W'(dmag);
        mn = MN_W'(17);
      end
      S_CORR_DIV: begin
        div_start = go;
        drem = DR_W'(num >> 17);
        dlow = {num[16:0], 16'h0000};
        dden = DR_W'(den_r);
        dn   = MN_W'(17);
      end
      S_COV_MUL: begin
        mul_start = go;
        ma = MA_W'(p);
        mb = MB_W'(r_eff);
        mn = MN_W'(33);
      end
      S_COV_DIV: begin
        div_start = go;
        drem = DR_W'(num >> 33);
        dlow = num[32:0];
        dden = DR_W'(den_r);
        dn   = MN_W'(33);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      yaw       <= '0;
      cov       <= 32'd65536;
    end else begin
      state  <= state_next;
      issued <= (issued || mul_start || div_start || cor_ctl.start) &&
                !(mul_done || div_done || cor_done);
      if (out_load) begin
        out_valid <= 1'b1;
        yaw       <= pred;
        cov       <= p;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      rate  <= 25'(in_ch.gyro_rate) - 25'(gyro_bias);
      dt    <= in_ch.time_step;
      dmx   <= 17'(in_ch.mag_raw_x) - 17'(mag_ofs_x);
      dmy   <= 17'(in_ch.mag_raw_y) - 17'(mag_ofs_y);
      dmz   <= 17'(in_ch.mag_raw_z) - 17'(mag_ofs_z);
      roll  <= in_ch.roll_angle;
      pitch <= in_ch.pitch_angle;
      p     <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
      r_eff <= (measure_noise != '0) ? measure_noise : DEFAULT_R;
      used  <= 1'b0;
      my    <= '0;
    end
    if (state == S_PRED_MUL && mul_done) begin
      pneg  <= prod[MP_W-1];
      num   <= NUM_W'(prod_abs[40:0]) + PRED_HALF;
      den_r <= {1'b0, p} + {1'b0, r_eff};
    end
    if (state == S_PRED_DIV && div_done) pred <= yaw + pinc;
    if (state == S_MY_MUL && mul_done) my <= prod[32:0];
    if (state == S_MZ_MUL && mul_done) begin
      mz   <= prod[32:0];
      used <= !mag_zero;
    end
    if ((state == S_SIN_ROLL || state == S_SIN_PITCH) && cor_ctl.start) begin
      trig_neg <= ang_hi || ang_lo;
    end
    if (state == S_SIN_ROLL && cor_done) begin
      sr <= trig_neg ? -ys : ys;
      cr <= trig_neg ? -xs : xs;
    end
    if (state == S_SIN_PITCH && cor_done) begin
      sp <= trig_neg ? -ys : ys;
      cp <= trig_neg ? -xs : xs;
    end
    if (state == S_SRSP_MUL && mul_done) srsp <= prod[32:15];
    if (state == S_SRCP_MUL && mul_done) srcp <= prod[32:15];
    if (state == S_XH_MUL1 && mul_done) xh <= prod[CX_W-1:0];
    if (state == S_XH_MUL2 && mul_done) xh <= xh + prod[CX_W-1:0];
    if (state == S_YH_MUL1 && mul_done) yh <= prod[CX_W-1:0];
    if (state == S_YH_MUL2 && mul_done) yh <= yh + prod[CX_W-1:0];
    if (state == S_YH_MUL3 && mul_done) yh <= yh - prod[CX_W-1:0];
    if (state == S_HEADING && (xy_zero || cor_done)) begin
      dneg <= dval[15];
      dmag <= {1'b0, dabs};
    end
    if (state == S_CORR_MUL && mul_done) begin
      num <= NUM_W'(prod[47:0]) + NUM_W'(den_r >> 1);
    end
    if (state == S_CORR_DIV && div_done) pred <= pred + cinc;
    if (state == S_COV_MUL && mul_done) begin
      num <= NUM_W'(prod[63:0]) + NUM_W'(den_r >> 1);
    end
    if (state == S_COV_DIV && div_done) p <= quo[31:0];
    if (out_load) begin
      out_yaw  <= pred;
      out_used <= used;
      out_cov  <= p;
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_one_unit_done: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_done, div_done, cor_done}))
    else $error("two arithmetic units finished together");

  a_cov_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.covariance != 32'd0))
    else $error("covariance collapsed to zero");
`endif

endmodule

@@ rtl/core/tcyk_mul.sv @@
// tcyk_mul: shift-add multiplier, one bit of the second operand per cycle,
// two's complement operand b of n bits; depends on tcyk_pkg
module tcyk_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [tcyk_pkg::MA_W-1:0] a,
  input  logic signed [tcyk_pkg::MB_W-1:0] b,
  input  logic [tcyk_pkg::MN_W-1:0]        n,
  output logic                           done,
  output logic signed [tcyk_pkg::MP_W-1:0] prod
);
  import tcyk_pkg::*;

  logic                   busy;
  logic signed [MP_W-1:0] a_sh;
  logic        [MB_W-1:0] b_sh;
  logic        [MN_W-1:0] cnt;
  logic signed [MP_W-1:0] acc;
  logic signed [MP_W-1:0] term;
  logic                   last;

  assign term = b_sh[0] ? a_sh : '0;
  assign last = (cnt == MN_W'(1));
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= MP_W'(a);
      b_sh <= b;
      cnt  <= n;
      acc  <= '0;
    end else if (busy) begin
      // top bit of b carries negative weight
      acc  <= last ? acc - term : acc + term;
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh >> 1;
      cnt  <= cnt - MN_W'(1);
    end
  end

endmodule

@@ rtl/core/tcyk_div.sv @@
// tcyk_div: restoring divider, one quotient bit per cycle
// depends on tcyk_pkg
module tcyk_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tcyk_pkg::DR_W-1:0] rem0,
  input  logic [tcyk_pkg::DQ_W-1:0] low,
  input  logic [tcyk_pkg::DR_W-1:0] den,
  input  logic [tcyk_pkg::MN_W-1:0] n,
  output logic                      done,
  output logic [tcyk_pkg::DQ_W-1:0] quo
);
  import tcyk_pkg::*;

  logic              busy;
  logic [DR_W-1:0]   rem;
  logic [DR_W-1:0]   den_r;
  logic [DQ_W-1:0]   low_sh;
  logic [MN_W-1:0]   cnt;
  logic [DR_W:0]     trial;
  logic [DR_W:0]     diff;
  logic              fits;
  logic              last;

  assign trial = {rem, low_sh[DQ_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});
  assign last  = (cnt == MN_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= rem0;
      den_r  <= den;
      low_sh <= low;
      cnt    <= n;
      quo    <= '0;
    end else if (busy) begin
      rem    <= fits ? diff[DR_W-1:0] : trial[DR_W-1:0];
      quo    <= {quo[DQ_W-2:0], fits};
      low_sh <= low_sh << 1;
      cnt    <= cnt - MN_W'(1);
    end
  end

endmodule

@@ rtl/core/tcyk_cordic.sv @@
// tcyk_cordic: iterative cordic, one micro-rotation per cycle, rotation or vectoring
// depends on tcyk_pkg
module tcyk_cordic (
  input  logic                             clk,
  input  logic                             rst,
  input  tcyk_pkg::cordic_ctl_t            ctl,
  input  logic signed [tcyk_pkg::CX_W-1:0] x0,
  input  logic signed [tcyk_pkg::CX_W-1:0] y0,
  input  logic signed [tcyk_pkg::CZ_W-1:0] z0,
  output logic                             done,
  output logic signed [tcyk_pkg::CX_W-1:0] x,
  output logic signed [tcyk_pkg::CX_W-1:0] y,
  output logic signed [tcyk_pkg::CZ_W-1:0] z
);
  import tcyk_pkg::*;

  logic                   busy;
  logic                   vec;
  logic [STEP_W-1:0]      step;
  logic signed [CX_W-1:0] dx;
  logic signed [CX_W-1:0] dy;
  logic signed [CZ_W-1:0] da;
  logic                   pos;
  logic                   last;

  assign dx   = y >>> step;
  assign dy   = x >>> step;
  assign da   = atan_step(step);
  assign pos  = vec ? y[CX_W-1] : ~z[CZ_W-1];
  assign last = (step == STEP_W'(NSTEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x    <= x0;
      y    <= y0;
      z    <= z0;
      vec  <= ctl.vector;
      step <= '0;
    end else if (busy) begin
      if (pos) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
      step <= step + STEP_W'(1);
    end
  end

endmodule
